// ===== hw/rtl/tapq_pkg.sv =====
package tapq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam logic [19:0] USEC_MAX = 20'd999999;

    localparam logic       FUNC_INSERT = 1'b0;
    localparam logic       FUNC_TICK   = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    typedef struct packed {
        logic              func;
        logic [31:0]       delay_sec;
        logic signed [7:0] priority_req;
        logic [15:0]       action_tag;
        logic              live;
        logic [31:0]       now_sec;
        logic [19:0]       now_usec;
        logic              timed_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_tag;
        logic        next_valid;
        logic [31:0] next_sec;
        logic [19:0] next_usec;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       sec;
        logic [19:0]       usec;
        logic signed [7:0] pri;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [15:0] tag;
        logic        live;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic pri_gt;
    } cmp_t;

endpackage

// ===== hw/rtl/tapq_cmp.sv =====
module tapq_cmp
    import tapq_pkg::*;
(
    input  key_t a,
    input  key_t b,
    output cmp_t res
);

    // date compare of a against b, plus priority tie-break
    always_comb
    begin
        res.lt     = (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec < b.usec));
        res.eq     = (a.sec == b.sec) && (a.usec == b.usec);
        res.pri_gt = (a.pri > b.pri);
    end

endmodule

// ===== hw/rtl/timed_action_priority_queue.sv =====
// Timed action queue kept sorted in service order in a register array. One
// date comparator is shared by a small sequencer. An insert walks from the
// tail toward the head, moving one entry per cycle; a full queue answers with
// a full beat only. A tick checks the head once per cycle while no fired beat
// is being sent, and pops a due head in the same cycle; a timed-out tick also
// pops one head that is not yet due. Result stalls hold the sequencer in its
// emit state. The command side stalls until every result beat of the
// current command has been taken.
module timed_action_priority_queue
    import tapq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_POP  = 5'b00100,
        S_SUM  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t         state_reg, ret_reg;
    entry_t         ent_reg [QUEUE_DEPTH];
    entry_t         new_reg;
    logic [CW-1:0]  occ_reg;
    logic [AW-1:0]  idx_reg;
    logic [31:0]    clk_sec_reg;
    logic [19:0]    clk_usec_reg;
    logic           forced_reg;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;

    key_t           cmp_a, cmp_b;
    cmp_t           cmp_res;
    logic [AW-1:0]  prev_idx;
    logic [32:0]    due_sum;
    logic           accept;
    logic           head_due;
    logic           occ_nz;

    assign prev_idx  = idx_reg - AW'(1);
    assign due_sum   = {1'b0, clk_sec_reg} + {1'b0, cmd.delay_sec};
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign occ_nz    = (occ_reg != '0);

    always_comb
    begin
        if (state_reg == S_INS)
        begin
            cmp_a = new_reg.key;
            cmp_b = ent_reg[prev_idx].key;
        end
        else
        begin
            cmp_a = ent_reg[0].key;
            cmp_b = '{sec: clk_sec_reg, usec: clk_usec_reg, pri: 8'sd0};
        end
    end

    tapq_cmp u_cmp
    (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign head_due = cmp_res.lt || cmp_res.eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            occ_reg       <= '0;
            idx_reg       <= '0;
            clk_sec_reg   <= '0;
            clk_usec_reg  <= '0;
            forced_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.func == FUNC_INSERT)
                        begin
                            if (occ_reg >= CW'(QUEUE_DEPTH))
                            begin
                                rsp_reg       <= '{kind: KIND_FULL, last: 1'b1, default: '0};
                                rsp_valid_reg <= 1'b1;
                                ret_reg       <= S_IDLE;
                                state_reg     <= S_EMIT;
                            end
                            else
                            begin
                                new_reg.key.sec  <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
                                new_reg.key.usec <= clk_usec_reg;
                                new_reg.key.pri  <= cmd.priority_req;
                                new_reg.tag      <= cmd.action_tag;
                                new_reg.live     <= cmd.live;
                                idx_reg          <= occ_reg[AW-1:0];
                                state_reg        <= S_INS;
                            end
                        end
                        else
                        begin
                            clk_sec_reg  <= cmd.now_sec;
                            clk_usec_reg <= (cmd.now_usec > USEC_MAX) ? USEC_MAX : cmd.now_usec;
                            forced_reg   <= cmd.timed_out;
                            state_reg    <= S_POP;
                        end
                    end
                end
                S_INS:
                begin
                    if ((idx_reg != '0) && (cmp_res.lt || (cmp_res.eq && cmp_res.pri_gt)))
                    begin
                        ent_reg[idx_reg] <= ent_reg[prev_idx];
                        idx_reg          <= prev_idx;
                    end
                    else
                    begin
                        ent_reg[idx_reg] <= new_reg;
                        occ_reg          <= occ_reg + CW'(1);
                        rsp_reg          <= '{kind: KIND_ACCEPTED, last: 1'b1, default: '0};
                        rsp_valid_reg    <= 1'b1;
                        ret_reg          <= S_IDLE;
                        state_reg        <= S_EMIT;
                    end
                end
                S_POP:
                begin
                    if (occ_nz && (head_due || forced_reg))
                    begin
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        begin
                            ent_reg[i] <= ent_reg[i+1];
                        end
                        occ_reg <= occ_reg - CW'(1);
                        if (!head_due)
                        begin
                            forced_reg <= 1'b0;
                        end
                        if (ent_reg[0].live)
                        begin
                            rsp_reg <= '{kind: KIND_FIRED, fired_tag: ent_reg[0].tag,
                                         default: '0};
                            rsp_valid_reg <= 1'b1;
                            ret_reg       <= head_due ? S_POP : S_SUM;
                            state_reg     <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= head_due ? S_POP : S_SUM;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    rsp_reg.kind       <= KIND_SUMMARY;
                    rsp_reg.fired_tag  <= '0;
                    rsp_reg.next_valid <= occ_nz;
                    rsp_reg.next_sec   <= occ_nz ? ent_reg[0].key.sec : 32'd0;
                    rsp_reg.next_usec  <= occ_nz ? ent_reg[0].key.usec : 20'd0;
                    rsp_reg.last       <= 1'b1;
                    rsp_valid_reg      <= 1'b1;
                    ret_reg            <= S_IDLE;
                    state_reg          <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_rsp_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (state_reg == S_EMIT))
        else $error("result beat outside emit");

    a_ins_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> ({1'b0, idx_reg} <= {1'b0, occ_reg}))
        else $error("insert index past tail");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_INS) && $past(state_reg) == S_IDLE) |-> (occ_reg < CW'(QUEUE_DEPTH)))
        else $error("insert walk on a full queue");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tapq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    timed_action_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // shadow of the action queue
    entry_t shadow_q[$];
    logic [31:0] clk_sec;
    logic [19:0] clk_usec;

    cmd_t pending_cmds[$];
    rsp_t expected_rsps[$];
    int errors;
    int cycles;
    logic quiet;
    int pause_req;

    function automatic logic runs_before(key_t a, key_t b);
        if (a.sec != b.sec)
            return a.sec < b.sec;
        if (a.usec != b.usec)
            return a.usec < b.usec;
        return a.pri > b.pri;
    endfunction

    function automatic rsp_t make_rsp(logic [1:0] k, logic [15:0] t, logic nv,
                                      logic [31:0] s, logic [19:0] u, logic l);
        rsp_t r;
        r.kind = k;
        r.fired_tag = t;
        r.next_valid = nv;
        r.next_sec = s;
        r.next_usec = u;
        r.last = l;
        return r;
    endfunction

    task automatic predict_queue(cmd_t c);
        entry_t e;
        logic [32:0] sum;
        int pos;
        logic [19:0] nu;
        if (c.func == FUNC_INSERT)
        begin
            if (shadow_q.size() >= DEPTH)
            begin
                expected_rsps.push_back(make_rsp(KIND_FULL, '0, 1'b0, '0, '0, 1'b1));
                return;
            end
            sum = {1'b0, clk_sec} + {1'b0, c.delay_sec};
            e.key.sec = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            e.key.usec = clk_usec;
            e.key.pri = c.priority_req;
            e.tag = c.action_tag;
            e.live = c.live;
            pos = 0;
            while (pos < shadow_q.size() && !runs_before(e.key, shadow_q[pos].key))
                pos++;
            shadow_q.insert(pos, e);
            expected_rsps.push_back(make_rsp(KIND_ACCEPTED, '0, 1'b0, '0, '0, 1'b1));
        end
        else
        begin
            nu = (c.now_usec > USEC_MAX) ? USEC_MAX : c.now_usec;
            clk_sec = c.now_sec;
            clk_usec = nu;
            while (shadow_q.size() > 0 && (shadow_q[0].key.sec < c.now_sec ||
                   (shadow_q[0].key.sec == c.now_sec && shadow_q[0].key.usec <= nu)))
            begin
                e = shadow_q.pop_front();
                if (e.live)
                    expected_rsps.push_back(make_rsp(KIND_FIRED, e.tag, 1'b0, '0, '0, 1'b0));
            end
            if (c.timed_out && shadow_q.size() > 0)
            begin
                e = shadow_q.pop_front();
                if (e.live)
                    expected_rsps.push_back(make_rsp(KIND_FIRED, e.tag, 1'b0, '0, '0, 1'b0));
            end
            if (shadow_q.size() > 0)
                expected_rsps.push_back(make_rsp(KIND_SUMMARY, '0, 1'b1,
                    shadow_q[0].key.sec, shadow_q[0].key.usec, 1'b1));
            else
                expected_rsps.push_back(make_rsp(KIND_SUMMARY, '0, 1'b0, '0, '0, 1'b1));
        end
    endtask

    function automatic cmd_t insert_cmd(logic [31:0] d, logic [7:0] p, logic [15:0] t,
                                        logic l);
        cmd_t c;
        c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom}));
        c.func = FUNC_INSERT;
        c.delay_sec = d;
        c.priority_req = p;
        c.action_tag = t;
        c.live = l;
        return c;
    endfunction

    function automatic cmd_t tick_cmd(logic [31:0] s, logic [19:0] u, logic f);
        cmd_t c;
        c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom}));
        c.func = FUNC_TICK;
        c.now_sec = s;
        c.now_usec = u;
        c.timed_out = f;
        return c;
    endfunction

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else if (!(cmd_valid && cmd_stall))
        begin
            if (cmd_valid)
                predict_queue(cmd);
            if (pending_cmds.size() > 0 && pause_req == 0 &&
                (quiet || $urandom_range(99) >= 12))
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected beat kind %0d", rsp.kind);
                    errors++;
                end
                else
                begin
                    rsp_t x;
                    x = expected_rsps.pop_front();
                    if (rsp.kind !== x.kind)
                    begin
                        $error("kind exp %0d got %0d", x.kind, rsp.kind);
                        errors++;
                    end
                    if (rsp.fired_tag !== x.fired_tag)
                    begin
                        $error("fired_tag exp %0h got %0h", x.fired_tag, rsp.fired_tag);
                        errors++;
                    end
                    if (rsp.next_valid !== x.next_valid)
                    begin
                        $error("next_valid exp %0d got %0d", x.next_valid, rsp.next_valid);
                        errors++;
                    end
                    if (rsp.next_sec !== x.next_sec)
                    begin
                        $error("next_sec exp %0h got %0h", x.next_sec, rsp.next_sec);
                        errors++;
                    end
                    if (rsp.next_usec !== x.next_usec)
                    begin
                        $error("next_usec exp %0d got %0d", x.next_usec, rsp.next_usec);
                        errors++;
                    end
                    if (rsp.last !== x.last)
                    begin
                        $error("last exp %0d got %0d", x.last, rsp.last);
                        errors++;
                    end
                end
            end
            rsp_stall <= !quiet && ($urandom_range(99) < 12);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        int r;
        int drain;
        logic [31:0] t_now;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        pause_req = 0;
        clk_sec = '0;
        clk_usec = '0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        pending_cmds.push_back(tick_cmd(32'd0, 20'd0, 1'b1));
        pending_cmds.push_back(insert_cmd(32'd5, 8'sd127, 16'hFFFF, 1'b1));
        pending_cmds.push_back(insert_cmd(32'd5, 8'h80, 16'h0001, 1'b1));
        pending_cmds.push_back(insert_cmd(32'd5, 8'sd127, 16'h0002, 1'b1));
        pending_cmds.push_back(insert_cmd(32'd0, 8'sd0, 16'h0003, 1'b0));
        pending_cmds.push_back(insert_cmd(32'hFFFF_FFFF, 8'sd0, 16'h0004, 1'b1));
        pending_cmds.push_back(tick_cmd(32'd0, 20'hFFFFF, 1'b0));
        pending_cmds.push_back(tick_cmd(32'd5, 20'd999999, 1'b0));
        pending_cmds.push_back(tick_cmd(32'd6, 20'd0, 1'b1));
        pending_cmds.push_back(tick_cmd(32'hFFFF_FFF0, 20'd12345, 1'b0));
        pending_cmds.push_back(insert_cmd(32'hFFFF_FFFF, 8'sd3, 16'h0005, 1'b1));
        pending_cmds.push_back(tick_cmd(32'hFFFF_FFFF, 20'd999999, 1'b0));
        pending_cmds.push_back(tick_cmd(32'd0, 20'd0, 1'b0));
        for (i = 0; i < DEPTH + 2; i++)
            pending_cmds.push_back(insert_cmd($urandom_range(3), 8'($urandom), 16'(i), i[0]));
        pending_cmds.push_back(tick_cmd(32'd1000, 20'd0, 1'b0));

        wait (pending_cmds.size() == 0 && !cmd_valid && expected_rsps.size() == 0);
        pause_req = 1;
        repeat (40) @(posedge clk);
        pause_req = 0;

        // random part
        t_now = 2000;
        for (i = 0; i < 72; i++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                pending_cmds.push_back(insert_cmd(($urandom_range(9) == 0) ? $urandom
                    : $urandom_range(20), 8'($urandom), 16'($urandom),
                    $urandom_range(3) != 0));
            else
            begin
                t_now = t_now + $urandom_range(8);
                if ($urandom_range(15) == 0)
                    t_now = $urandom;
                pending_cmds.push_back(tick_cmd(t_now, 20'(($urandom_range(9) == 0) ? $urandom
                    : $urandom_range(999999)), $urandom_range(4) == 0));
            end
            if (i == 24)
            begin
                wait (pending_cmds.size() == 0);
                quiet = 1'b1;
            end
            if (i == 54)
            begin
                wait (pending_cmds.size() == 0);
                quiet = 1'b0;
            end
        end
        wait (pending_cmds.size() == 0 && !cmd_valid);
        wait (expected_rsps.size() == 0);
        drain = 0;
        while (drain < 200)
        begin
            @(posedge clk);
            drain++;
        end
        if (errors == 0 && expected_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
